FILE: sv/slfs_pkg.sv
package slfs_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int ROWS_DEF    = 32;

  // 255^3, denominator of the squared gamma test
  localparam longint unsigned GAMMA_DEN = 64'd16581375;

  typedef struct packed {
    logic       mode;
    logic [4:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
  } store_ctl_t;

  typedef logic [3:0] gamma_lut_t [256];

  // Level h is reached when (16h)^2 * 255^3 <= v^5, i.e. floor(255*(v/255)^2.5) >= 16h.
  function automatic gamma_lut_t build_gamma_lut();
    gamma_lut_t      lut;
    longint unsigned x;
    longint unsigned v5;
    for (int v = 0; v < 256; v++) begin
      x = 64'(v);
      v5 = x * x * x * x * x;
      lut[v] = 4'd0;
      for (int h = 1; h < 16; h++) begin
        if (64'(256) * 64'(h) * 64'(h) * GAMMA_DEN <= v5) begin
          lut[v] = 4'(h);
        end
      end
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = b[i];
    end
    return r;
  endfunction

endpackage

FILE: sv/slfs_store.sv
module slfs_store import slfs_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int DEPTH  = ROWS * COLUMNS,
  localparam int AW     = $clog2(DEPTH),
  localparam int RIW    = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_ctl_t       ctl_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [23:0]      wr_data_i,
  input  logic [RIW-1:0]   row_idx_i,
  output logic [23:0]      rd_data_o
);

  logic [23:0]     mem [DEPTH];
  logic [23:0]     rdata_q;
  logic            rd_valid_q;
  logic [ROWS-1:0] row_valid_q;

  // read-before-write on the same address
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q    <= mem[rd_addr_i];
      rd_valid_q <= row_valid_q[row_idx_i];
    end
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // a row reads black until its first full rewrite
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (ctl_i.set_valid) begin
      row_valid_q[row_idx_i] <= 1'b1;
    end
  end

  assign rd_data_o = rd_valid_q ? rdata_q : 24'd0;

  a_valid_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.set_valid |-> ctl_i.wr_en)
    else $error("row marked valid without a write");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.rd_en |-> (int'(rd_addr_i) < DEPTH))
    else $error("read address beyond the store");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.wr_en |-> (int'(wr_addr_i) < DEPTH))
    else $error("write address beyond the store");

endmodule

FILE: sv/scrolling_led_frame_serializer.sv
// LED matrix frame store with row serializer. The store holds ROWS x COLUMNS
// 24-bit RGB pixels, all black after reset. A beat is taken when start is
// high and busy is low. An insert beat (mode 0) shifts its row right by one
// column, dropping the last column, and puts {red, green, blue} in column 0;
// it keeps busy high while it walks the row, one column per cycle through the
// store's read and write ports, and gives no results. A send beat (mode 1)
// walks the row in even/odd pixel pairs, gamma corrects each channel to 4
// bits and emits three bit-reversed bytes per pair, last_byte set on the
// final one: 3*ceil(COLUMNS/2) bytes, one per cycle, the first formed in the
// RD1 phase and registered. A pair passes phases RD0, RD1 and PAIR as two
// reads share one read port, and busy stays high through every pair and the
// DRAIN state; the next beat may be taken while the final byte is shown.
// Each byte stands on out_item_o for exactly one cycle with out_strobe_o
// high and cannot be held off: the receiver must take every strobed beat.
// A beat naming a row at or beyond ROWS is taken and ignored, busy stays
// low. With an odd column count the last pixel is paired with black. Rows
// start out black through per-row valid bits, so no clearing pass runs
// after reset.
module scrolling_led_frame_serializer import slfs_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item_i,
  output logic      out_strobe_o,
  output out_item_t out_item_o
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int CW1   = CW + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_SEND  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  // send phases within one pixel pair
  localparam logic [1:0] PH_RD0  = 2'd0;  // read even pixel, emit byte 2 of prior pair
  localparam logic [1:0] PH_RD1  = 2'd1;  // read odd pixel, emit byte 0
  localparam logic [1:0] PH_PAIR = 2'd2;  // emit byte 1

  logic [1:0]     state_q, state_d;
  logic [1:0]     ph_q, ph_d;
  logic [CW-1:0]  col_q, col_d;
  logic [AW-1:0]  base_q, base_d;
  logic [RIW-1:0] row_idx_q, row_idx_d;
  logic [23:0]    px_q, px_d;
  logic [3:0]     b0_q, b0_d, b1_q, b1_d, g1_q, g1_d;
  out_item_t      out_q, out_d;
  logic           strobe_q, strobe_d;

  store_ctl_t     st_ctl;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [23:0]    wr_data, rd_data;

  logic           accept, row_ok, partner, last_pair, last_col;
  logic [3:0]     gr, gg, gb;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign row_ok = int'(in_item_i.row) < ROWS;

  assign last_col  = (col_q == CW'(COLUMNS - 1));
  assign partner   = (CW1'(col_q) + CW1'(1)) < CW1'(COLUMNS);
  assign last_pair = (CW1'(col_q) + CW1'(2)) >= CW1'(COLUMNS);

  assign gr = GAMMA_LUT[rd_data[23:16]];
  assign gg = GAMMA_LUT[rd_data[15:8]];
  assign gb = GAMMA_LUT[rd_data[7:0]];

  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    col_d     = col_q;
    base_d    = base_q;
    row_idx_d = row_idx_q;
    px_d      = px_q;
    b0_d      = b0_q;
    b1_d      = b1_q;
    g1_d      = g1_q;
    out_d     = out_q;
    strobe_d  = 1'b0;
    st_ctl    = '0;
    rd_addr   = base_q + AW'(col_q);
    wr_addr   = base_q + AW'(col_q);
    wr_data   = rd_data;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && row_ok) begin
          base_d    = AW'(int'(in_item_i.row) * COLUMNS);
          row_idx_d = RIW'(in_item_i.row);
          px_d      = {in_item_i.red, in_item_i.green, in_item_i.blue};
          col_d     = '0;
          ph_d      = PH_RD0;
          state_d   = in_item_i.mode ? ST_SEND : ST_SHIFT;
        end
      end

      // column c takes the old column c-1, read in the cycle before; column 0 takes the new pixel
      ST_SHIFT: begin
        st_ctl.rd_en = !last_col;
        st_ctl.wr_en = 1'b1;
        wr_data      = (col_q == '0) ? px_q : rd_data;
        if (last_col) begin
          st_ctl.set_valid = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          col_d = col_q + CW'(1);
        end
      end

      ST_SEND: begin
        unique case (ph_q)
          PH_RD0: begin
            st_ctl.rd_en = 1'b1;
            if (col_q != '0) begin
              out_d    = '{out_byte: rev8({b1_q, g1_q}), last_byte: 1'b0};
              strobe_d = 1'b1;
            end
            ph_d = PH_RD1;
          end
          PH_RD1: begin
            st_ctl.rd_en = partner;
            rd_addr      = base_q + AW'(col_q) + AW'(1);
            out_d        = '{out_byte: rev8({gg, gr}), last_byte: 1'b0};
            strobe_d     = 1'b1;
            b0_d         = gb;
            ph_d         = PH_PAIR;
          end
          PH_PAIR: begin
            out_d    = '{out_byte: rev8({partner ? gr : 4'd0, b0_q}), last_byte: 1'b0};
            strobe_d = 1'b1;
            b1_d     = partner ? gb : 4'd0;
            g1_d     = partner ? gg : 4'd0;
            ph_d     = PH_RD0;
            if (last_pair) begin
              state_d = ST_DRAIN;
            end else begin
              col_d = col_q + CW'(2);
            end
          end
          default: begin
            ph_d = PH_RD0;
          end
        endcase
      end

      ST_DRAIN: begin
        out_d    = '{out_byte: rev8({b1_q, g1_q}), last_byte: 1'b1};
        strobe_d = 1'b1;
        state_d  = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ph_q     <= PH_RD0;
      col_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      col_q    <= col_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    row_idx_q <= row_idx_d;
    px_q      <= px_d;
    b0_q      <= b0_d;
    b1_q      <= b1_d;
    g1_q      <= g1_d;
    out_q     <= out_d;
  end

  slfs_store #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (st_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .row_idx_i(row_idx_q),
    .rd_data_o(rd_data)
  );

  assign out_strobe_o = strobe_q;
  assign out_item_o   = out_q;

  a_strobe_from_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(state_q == ST_SEND || state_q == ST_DRAIN))
    else $error("byte strobed outside a send");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && out_item_o.last_byte) |=> !out_strobe_o)
    else $error("byte strobed right after the last byte of a row");

  a_no_write_in_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_ctl.wr_en |-> (state_q == ST_SHIFT && !out_strobe_o && !strobe_d))
    else $error("store written while bytes are being sent");

endmodule

FILE: tb/tb_scrolling_led_frame_serializer.sv
module tb_scrolling_led_frame_serializer;
  import slfs_pkg::*;

  localparam int COLS_N     = COLUMNS_DEF;
  localparam int ROWS_N     = ROWS_DEF;
  // Slowest run: ~300 beats, each a full send plus a sender gap; the limit
  // is ten times the length of that run.
  localparam int CYCLE_LIMIT = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  // Shadow copy of the frame store, one 24-bit RGB word per pixel.
  logic [23:0] pixel_shadow [ROWS_N][COLS_N];
  // Bytes a send is still owed, oldest first.
  out_item_t   pending_bytes [$];
  out_item_t   want_beat;
  int          mismatch_cnt;
  int          cycle_cnt;
  // Sender gaps only while this is set; cleared for no-gap stretches.
  bit          gaps_on;

  scrolling_led_frame_serializer #(
    .COLUMNS(COLS_N),
    .ROWS   (ROWS_N)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_item_i   (in_item),
    .out_strobe_o(out_strobe),
    .out_item_o  (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost byte ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bytes still owed", $time, pending_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Largest g with g^2 * 255^3 <= v^5 is floor(255*(v/255)^2.5); keep top nibble.
  function automatic logic [3:0] gamma_nibble(input logic [7:0] v);
    longint unsigned x;
    longint unsigned v5;
    longint unsigned lvl;
    x   = 64'(v);
    v5  = x * x * x * x * x;
    lvl = 0;
    for (longint unsigned g = 1; g < 256; g++) begin
      if (g * g * GAMMA_DEN <= v5) lvl = g;
    end
    return lvl[7:4];
  endfunction

  function automatic logic [7:0] mirror_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = b[7 - i];
    return r;
  endfunction

  // Apply one accepted beat to the shadow store; a send queues its bytes.
  task automatic frame_apply(input in_item_t it);
    logic [23:0] p0;
    logic [23:0] p1;
    logic [3:0]  r0, g0, b0, r1, g1, b1;
    logic [7:0]  trio [3];
    out_item_t   beat;
    int          total;
    int          n;
    if (int'(it.row) >= ROWS_N) return;   // out-of-range row: dropped
    if (!it.mode) begin
      // Shift right; last column falls off, new pixel lands in column 0.
      for (int c = COLS_N - 1; c >= 1; c--) pixel_shadow[it.row][c] = pixel_shadow[it.row][c - 1];
      pixel_shadow[it.row][0] = {it.red, it.green, it.blue};
    end else begin
      total = 3 * ((COLS_N + 1) / 2);
      n     = 0;
      for (int c = 0; c < COLS_N; c += 2) begin
        p0 = pixel_shadow[it.row][c];
        // odd column count: partner of the last pixel is black
        p1 = (c + 1 < COLS_N) ? pixel_shadow[it.row][c + 1] : 24'h0;
        r0 = gamma_nibble(p0[23:16]);
        g0 = gamma_nibble(p0[15:8]);
        b0 = gamma_nibble(p0[7:0]);
        r1 = gamma_nibble(p1[23:16]);
        g1 = gamma_nibble(p1[15:8]);
        b1 = gamma_nibble(p1[7:0]);
        trio[0] = mirror_byte({g0, r0});
        trio[1] = mirror_byte({r1, b0});
        trio[2] = mirror_byte({b1, g1});
        for (int k = 0; k < 3; k++) begin
          beat.out_byte  = trio[k];
          beat.last_byte = (n + 1 == total);
          pending_bytes.push_back(beat);
          n++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checker: every strobed byte must match the oldest owed byte.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_strobe) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: byte with nothing owed: expected none, actual byte %h last %b",
                 $time, out_item.out_byte, out_item.last_byte);
        mismatch_cnt++;
      end else begin
        want_beat = pending_bytes.pop_front();
        if (out_item.out_byte !== want_beat.out_byte) begin
          $display("%0t: out_byte mismatch: expected %h actual %h",
                   $time, want_beat.out_byte, out_item.out_byte);
          mismatch_cnt++;
        end
        if (out_item.last_byte !== want_beat.last_byte) begin
          $display("%0t: last_byte mismatch: expected %b actual %b",
                   $time, want_beat.last_byte, out_item.last_byte);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t pixel_beat(input logic [4:0] row, input logic [23:0] rgb);
    in_item_t it;
    it.mode  = 1'b0;
    it.row   = row;
    it.red   = rgb[23:16];
    it.green = rgb[15:8];
    it.blue  = rgb[7:0];
    return it;
  endfunction

  function automatic in_item_t row_send_beat(input logic [4:0] row);
    in_item_t it;
    it       = '0;
    it.mode  = 1'b1;
    it.row   = row;
    // color fields are don't-care on a send; drive noise into them
    it.red   = 8'($urandom);
    it.green = 8'($urandom);
    it.blue  = 8'($urandom);
    return it;
  endfunction

  // Present one beat and hold it until taken. start stays high on return so a
  // back-to-back beat never drops and re-raises it in one time step; the next
  // call lowers it ahead of a gap, and drain_bytes lowers it for a drain.
  task automatic drive_beat(input in_item_t it);
    int gap;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    frame_apply(it);
  endtask

  // Stop sending and let every owed byte come out.
  task automatic drain_bytes();
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly a few hot rows so they get shifted past their full width.
  function automatic logic [4:0] pick_row();
    case ($urandom_range(0, 9))
      0, 1, 2: return 5'd2;
      3, 4:    return 5'd21;
      5:       return 5'd31;
      default: return 5'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh store reads back all black, first and last row.
  task automatic test_black_after_reset();
    drive_beat(row_send_beat(5'd0));
    drive_beat(row_send_beat(5'd31));
  endtask

  // Channel extremes and mid values through one row, then read it out.
  task automatic test_pixel_extremes();
    drive_beat(pixel_beat(5'd0, 24'hffffff));
    drive_beat(pixel_beat(5'd0, 24'h000000));
    drive_beat(pixel_beat(5'd0, 24'hff0000));
    drive_beat(pixel_beat(5'd0, 24'h00ff00));
    drive_beat(pixel_beat(5'd0, 24'h0000ff));
    drive_beat(pixel_beat(5'd0, 24'h808080));
    drive_beat(pixel_beat(5'd0, 24'h010101));
    drive_beat(pixel_beat(5'd0, 24'hfefefe));
    drive_beat(pixel_beat(5'd0, 24'h5aa5c3));
    drive_beat(row_send_beat(5'd0));
  endtask

  // A write to one row leaves the others alone.
  task automatic test_row_isolation();
    drive_beat(pixel_beat(5'd31, 24'ha7c3e5));
    drive_beat(pixel_beat(5'd16, 24'h3c7e19));
    drive_beat(row_send_beat(5'd31));
    drive_beat(row_send_beat(5'd0));
  endtask

  // Sends, with one insert among them, and no gap: the beat after a send is taken while its last byte is shown.
  task automatic test_back_to_back_sends();
    gaps_on = 1'b0;
    drive_beat(row_send_beat(5'd0));
    drive_beat(row_send_beat(5'd16));
    drive_beat(pixel_beat(5'd16, 24'hffffff));
    drive_beat(row_send_beat(5'd16));
    gaps_on = 1'b1;
  endtask

  // Bursts of inserts into a row followed by a send of it, with stray beats
  // mixed in.
  task automatic test_random_scroll(input int n_beats, input bit allow_gaps);
    int         sent;
    int         n_ins;
    logic [4:0] row;
    sent = 0;
    while (sent < n_beats) begin
      gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        // stray beat: random kind, random row
        if ($urandom_range(0, 1) == 0) drive_beat(row_send_beat(5'($urandom)));
        else drive_beat(pixel_beat(5'($urandom), {pick_channel(), pick_channel(), pick_channel()}));
        sent++;
      end else begin
        row   = pick_row();
        n_ins = $urandom_range(0, 12);
        for (int i = 0; i < n_ins; i++) begin
          drive_beat(pixel_beat(row, {pick_channel(), pick_channel(), pick_channel()}));
        end
        drive_beat(row_send_beat(row));
        sent += n_ins + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    gaps_on      = 1'b1;
    for (int r = 0; r < ROWS_N; r++) begin
      for (int c = 0; c < COLS_N; c++) pixel_shadow[r][c] = 24'h0;
    end
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_black_after_reset();
    test_pixel_extremes();
    test_row_isolation();
    test_back_to_back_sends();
    test_random_scroll(150, 1'b1);
    // hold off until every owed byte is out, then resume
    drain_bytes();
    test_random_scroll(50, 1'b0);

    drain_bytes();
    // an insert may still be walking its row with nothing owed
    repeat (3 * COLS_N + 8) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
